// ===== hw/rtl/trail_point_buffer_top_macros.svh =====
// Assertion helpers shared by the checker; clock and reset are clk and rst.
`ifndef TRAIL_POINT_BUFFER_TOP_MACROS_SVH
`define TRAIL_POINT_BUFFER_TOP_MACROS_SVH

// Same-cycle implication.
`define TPB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trail point buffer check failed");

// Next-cycle implication.
`define TPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trail point buffer check failed");

`endif

// ===== hw/rtl/tpb_pkg.sv =====
package tpb_pkg;

  localparam int DEPTH_DEF      = 2048;
  localparam int COORD_BITS_DEF = 32;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 24;
  localparam int PADDR_W     = 5;

  // register indexes
  localparam logic [2:0] REG_EMIT  = 3'd0;
  localparam logic [2:0] REG_LIFE  = 3'd1;
  localparam logic [2:0] REG_STEP  = 3'd2;
  localparam logic [2:0] REG_SPAN  = 3'd3;
  localparam logic [2:0] REG_MAXPT = 3'd4;

  // reset values
  localparam logic        EMIT_RST  = 1'b1;
  localparam logic [20:0] LIFE_RST  = 21'd16384;
  localparam logic [19:0] STEP_RST  = 20'd1311;
  localparam logic [29:0] SPAN_RST  = 30'd196608;
  localparam logic [11:0] MAXPT_RST = 12'd64;

  // clamp ranges
  localparam logic [21:0] ELAPSED_SAT = 22'd3932160;
  localparam logic [20:0] LIFE_LO     = 21'd655;
  localparam logic [20:0] LIFE_HI     = 21'd1966080;
  localparam logic [19:0] STEP_LO     = 20'd7;
  localparam logic [19:0] STEP_HI     = 20'd655360;
  localparam logic [29:0] SPAN_LO     = 30'd655;
  localparam logic [29:0] SPAN_HI     = 30'd655360000;
  localparam logic [11:0] PTS_LO      = 12'd2;
  localparam logic [11:0] PTS_HI      = 12'd2048;

  typedef struct packed {
    logic        emit_enable;
    logic [20:0] lifetime;
    logic [19:0] min_step;
    logic [29:0] break_span;
    logic [11:0] max_points;
  } cfg_t;

endpackage

// ===== hw/rtl/tpb_point_mem.sv =====
module tpb_point_mem import tpb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/tpb_cfg_regs.sv =====
module tpb_cfg_regs import tpb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr_hit;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.emit_enable <= EMIT_RST;
      cfg.lifetime    <= LIFE_RST;
      cfg.min_step    <= STEP_RST;
      cfg.break_span  <= SPAN_RST;
      cfg.max_points  <= MAXPT_RST;
    end else if (wr_hit) begin
      unique case (reg_idx)
        REG_EMIT:  cfg.emit_enable <= pwdata[0];
        REG_LIFE:  cfg.lifetime    <= pwdata[20:0];
        REG_STEP:  cfg.min_step    <= pwdata[19:0];
        REG_SPAN:  cfg.break_span  <= pwdata[29:0];
        REG_MAXPT: cfg.max_points  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EMIT:  prdata = {31'd0, cfg.emit_enable};
      REG_LIFE:  prdata = {11'd0, cfg.lifetime};
      REG_STEP:  prdata = {12'd0, cfg.min_step};
      REG_SPAN:  prdata = {2'd0, cfg.break_span};
      REG_MAXPT: prdata = {20'd0, cfg.max_points};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/tpb_seq.sv =====
module tpb_seq import tpb_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int COORD_W = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int EXW  = $clog2(DEPTH + 2),
  localparam int MW   = 3 * COORD_W + 32,
  localparam int DW   = COORD_W + 1,
  localparam int CMPW = (DW > 30) ? DW : 30
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]             m_axis_tuser,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [MW-1:0]          rd_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [MW-1:0]          wr_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXP_RD  = 4'd1;
  localparam logic [3:0] S_EXP_CHK = 4'd2;
  localparam logic [3:0] S_EMIT    = 4'd3;
  localparam logic [3:0] S_DIST    = 4'd4;
  localparam logic [3:0] S_MUL     = 4'd5;
  localparam logic [3:0] S_ACC     = 4'd6;
  localparam logic [3:0] S_CMP     = 4'd7;
  localparam logic [3:0] S_APPEND  = 4'd8;
  localparam logic [3:0] S_TRIM    = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [3:0]         state;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [31:0]        now_time;
  logic [EXW-1:0]     expired;
  logic               app_flag;
  logic               clr_flag;
  logic [COORD_W-1:0] x_in, y_in, z_in;
  logic [29:0]        ax, ay, az;
  logic [2:0]         idx;
  logic [59:0]        prod;
  logic [61:0]        d2;
  logic [59:0]        span2;
  logic [38:0]        step2;

  logic [20:0]   life;
  logic [19:0]   step;
  logic [29:0]   span;
  logic [11:0]   lim12;
  logic [CW-1:0] limit;
  logic [21:0]   dt;
  logic [31:0]   age;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] last_addr;
  logic [AW-1:0] slot_addr;
  logic [CW-1:0] trim_n;
  logic [AW-1:0] head_trim;
  logic [CMPW-1:0] ext_ax, ext_ay, ext_az, ext_span;
  logic [29:0]   mul_op;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(n);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [CMPW-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        m;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    m = d[DW-1] ? DW'(-d) : DW'(d);
    return CMPW'(m);
  endfunction

  // clamp registers on use
  always_comb begin
    life  = (cfg.lifetime < LIFE_LO) ? LIFE_LO :
            ((cfg.lifetime > LIFE_HI) ? LIFE_HI : cfg.lifetime);
    step  = (cfg.min_step < STEP_LO) ? STEP_LO :
            ((cfg.min_step > STEP_HI) ? STEP_HI : cfg.min_step);
    span  = (cfg.break_span < SPAN_LO) ? SPAN_LO :
            ((cfg.break_span > SPAN_HI) ? SPAN_HI : cfg.break_span);
    lim12 = (cfg.max_points < PTS_LO) ? PTS_LO :
            ((cfg.max_points > PTS_HI) ? PTS_HI : cfg.max_points);
    limit = ({1'b0, lim12} > 13'(DEPTH)) ? DEPTH_C : CW'(lim12);
  end

  always_comb begin
    dt        = (s_axis_tdata[117:96] > ELAPSED_SAT) ? ELAPSED_SAT : s_axis_tdata[117:96];
    age       = now_time - rd_data[31:0];
    head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;
    last_addr = wrap_add(head, count - 1'b1);
    slot_addr = wrap_add(head, count);
    trim_n    = count - limit;
    head_trim = wrap_add(head, trim_n);
    ext_ax    = abs_diff(x_in, rd_data[32 +: COORD_W]);
    ext_ay    = abs_diff(y_in, rd_data[32 + COORD_W +: COORD_W]);
    ext_az    = abs_diff(z_in, rd_data[32 + 2 * COORD_W +: COORD_W]);
    ext_span  = CMPW'(span);
    case (idx)
      3'd0:    mul_op = ax;
      3'd1:    mul_op = ay;
      3'd2:    mul_op = az;
      3'd3:    mul_op = span;
      default: mul_op = {10'd0, step};
    endcase
  end

  // one read port: head for expiry, newest entry for the distance test
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    if (state == S_EXP_RD && count != '0) begin
      rd_en = 1'b1;
    end else if (state == S_EMIT && cfg.emit_enable && count != '0) begin
      rd_en   = 1'b1;
      rd_addr = last_addr;
    end
    wr_en   = (state == S_APPEND);
    wr_addr = (count == DEPTH_C) ? head : slot_addr;
    wr_data = {z_in, y_in, x_in, now_time};
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      count         <= '0;
      now_time      <= '0;
      expired       <= '0;
      app_flag      <= 1'b0;
      clr_flag      <= 1'b0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x_in     <= s_axis_tdata[COORD_W-1:0];
            y_in     <= s_axis_tdata[32 +: COORD_W];
            z_in     <= s_axis_tdata[64 +: COORD_W];
            expired  <= '0;
            app_flag <= 1'b0;
            if (!s_axis_tuser[0] || !s_axis_tuser[1]) begin
              // drop the whole trail; the clock holds
              count    <= '0;
              clr_flag <= 1'b1;
              state    <= S_DONE;
            end else begin
              now_time <= now_time + 32'(dt);
              clr_flag <= 1'b0;
              state    <= S_EXP_RD;
            end
          end
        end
        S_EXP_RD: begin
          state <= (count != '0) ? S_EXP_CHK : S_EMIT;
        end
        S_EXP_CHK: begin
          if (age >= 32'(life)) begin
            head    <= head_inc;
            count   <= count - 1'b1;
            expired <= expired + 1'b1;
            state   <= S_EXP_RD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!cfg.emit_enable) begin
            state <= S_TRIM;
          end else if (count == '0) begin
            state <= S_APPEND;
          end else begin
            state <= S_DIST;
          end
        end
        S_DIST: begin
          if (ext_ax > ext_span || ext_ay > ext_span || ext_az > ext_span) begin
            count    <= '0;
            clr_flag <= 1'b1;
            state    <= S_APPEND;
          end else begin
            ax    <= ext_ax[29:0];
            ay    <= ext_ay[29:0];
            az    <= ext_az[29:0];
            idx   <= '0;
            d2    <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_op * mul_op;
          state <= S_ACC;
        end
        S_ACC: begin
          case (idx)
            3'd0, 3'd1, 3'd2: d2 <= d2 + 62'(prod);
            3'd3:             span2 <= prod;
            default:          step2 <= prod[38:0];
          endcase
          if (idx == 3'd4) begin
            state <= S_CMP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MUL;
          end
        end
        S_CMP: begin
          if (d2 > 62'(span2)) begin
            count    <= '0;
            clr_flag <= 1'b1;
            state    <= S_APPEND;
          end else if (d2 >= 62'(step2)) begin
            state <= S_APPEND;
          end else begin
            state <= S_TRIM;
          end
        end
        S_APPEND: begin
          app_flag <= 1'b1;
          if (count == DEPTH_C) begin
            // full: the new point overwrites the head slot
            head    <= head_inc;
            expired <= expired + 1'b1;
          end else begin
            count <= count + 1'b1;
          end
          state <= S_TRIM;
        end
        S_TRIM: begin
          if (count > limit) begin
            count   <= limit;
            head    <= head_trim;
            expired <= expired + EXW'(trim_n);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid      <= 1'b1;
            m_axis_tdata[11:0] <= 12'(count);
            m_axis_tdata[23:12] <= (32'(expired) > 32'd4095) ? 12'd4095 : 12'(expired);
            m_axis_tuser       <= {clr_flag, app_flag};
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/trail_point_buffer_top.sv =====
// Trail point buffer: keeps the recent path of a moving owner as a ring of
// 3-D points with birth stamps, in one single-port-read memory of DEPTH
// entries. Each input item is one tick: a position, the tick time and two
// qualifiers. A tick with the owner inactive or the position invalid empties
// the trail (cleared = 1). Any other tick advances the Q16.16 clock, expires
// points from the head (one memory read and one compare per point) and, with
// emit enabled, runs the distance test against the newest point on a single
// shared 30x30 multiplier (five squares), appends unless the step is too
// short, and trims. One item is worked at a time; the next tick is taken
// while its result still waits in the output register. The store needs no
// clearing pass: only entries inside the live window are ever read, and a
// write never overlaps a read of the same item. Registers are to be written
// by the user over the APB port only while the block is idle; the block
// itself does not enforce this.
module trail_point_buffer_top import tpb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], elapsed[117:96], zero fill
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: active[0], position_valid[1]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: point_count[11:0], expired_count[23:12]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: appended[0], cleared[1]
  output logic [1:0]             m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // coordinates are kept at no more than 32 bits each
  localparam int COORD_W = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW      = 3 * COORD_W + 32;

  cfg_t          cfg;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [MW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  tpb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // entry layout from bit 0: birth stamp, x, y, z
  tpb_point_mem #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tpb_seq #(
    .DEPTH   (DEPTH),
    .COORD_W (COORD_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

endmodule

// ===== hw/rtl/tpb_checker.sv =====
`include "trail_point_buffer_top_macros.svh"

module tpb_checker import tpb_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [PADDR_W-1:0]     paddr,
  input logic [31:0]            pwdata,
  input logic [31:0]            prdata,
  input logic                   pready
);

  // a stalled result holds
  `TPB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // one item in flight: no second accept right after one
  `TPB_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // an append always leaves at least one point
  `TPB_ASSERT_SAME(a_append_count, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[11:0] != 12'd0)
  // a clear without append leaves the trail empty
  `TPB_ASSERT_SAME(a_clear_empty, m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0], m_axis_tdata[11:0] == 12'd0)
  // trimming keeps the count within the largest point limit
  `TPB_ASSERT_SAME(a_count_limit, m_axis_tvalid, m_axis_tdata[11:0] <= PTS_HI)

endmodule

bind trail_point_buffer_top tpb_checker u_tpb_checker (.*);
